@@ rtl/lzsswd_pkg.sv @@
// ----------------------------------------------------------------------------
// LZSS window decoder package
// Shared constants, register indexes and the structs passed between the
// control sequencer, the history window and the top level.
// ----------------------------------------------------------------------------
package lzsswd_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int WINDOW_SIZE_DEF = 4096;
  localparam int LENGTH_BITS_DEF = 32;

  // Configuration port geometry.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STOP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'b1;

  // Window write position after a restart.
  localparam logic [11:0] WPOS_START = 12'hFEE;

  // Shortest match length; the length nibble is added to it.
  localparam logic [4:0] MIN_MATCH = 5'd3;

  // Token phase codes.
  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // Configuration register contents.
  typedef struct packed {
    logic             stop;
    logic [CFG_W-1:0] length;
  } cfg_t;

  // One decoded byte offered to the output stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_t;

  // Window control from the sequencer.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic restart;
  } win_ctl_t;

endpackage

@@ rtl/lzsswd_window.sv @@
// ----------------------------------------------------------------------------
// LZSS history window
// Single-port-write, single-port-read synchronous memory holding the last
// decoded bytes. Writes always land at the running write position. A fill
// count marks which entries were written since the last restart; any other
// entry reads as zero, so the memory never needs a clearing pass.
// ----------------------------------------------------------------------------
module lzsswd_window
  import lzsswd_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  win_ctl_t                       ctl,
  input  logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
  input  logic [7:0]                     wr_data,
  output logic [7:0]                     rd_data
);

  localparam int AW = $clog2(WINDOW_SIZE);

  logic [7:0]    mem [WINDOW_SIZE];
  logic [AW-1:0] wpos_r;
  logic [AW:0]   fill_r;
  logic [7:0]    rd_q_r;
  logic          rd_ok_r;
  logic [AW-1:0] rel_addr;
  logic          rd_written;

  // Entries written since restart form a run starting at the start position.
  assign rel_addr   = rd_addr - AW'(WPOS_START);
  assign rd_written = {1'b0, rel_addr} < fill_r;

  // Write position and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.restart) begin
      wpos_r <= AW'(WPOS_START);
      fill_r <= '0;
    end else if (ctl.wr_en) begin
      wpos_r <= wpos_r + 1'b1;
      if (fill_r != (AW+1)'(WINDOW_SIZE)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wpos_r] <= wr_data;
    end
  end

  // Registered read port with the written-entry flag.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q_r  <= mem[rd_addr];
      rd_ok_r <= rd_written;
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : 8'h00;

endmodule

@@ rtl/lzsswd_ctrl.sv @@
// ----------------------------------------------------------------------------
// LZSS token sequencer
// Parses flag bytes, literals and two-byte matches, runs the match copy as
// a read/emit loop over the history window and keeps the output count used
// by limit mode.
// ----------------------------------------------------------------------------
module lzsswd_ctrl
  import lzsswd_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  input  cfg_t                           cfg,
  output emit_t                          emit,
  input  logic                           emit_ready,
  output win_ctl_t                       win_ctl,
  output logic [$clog2(WINDOW_SIZE)-1:0] win_rd_addr,
  output logic [7:0]                     win_wr_data,
  input  logic [7:0]                     win_rd_data
);

  localparam int AW = $clog2(WINDOW_SIZE);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LIT  = 4'b0010,
    S_RD   = 4'b0100,
    S_WR   = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [15:0]            flags_r, flags_nxt;
  logic [7:0]             offlo_r, offlo_nxt;
  logic [7:0]             lit_r, lit_nxt;
  logic                   last_r, last_nxt;
  logic [AW-1:0]          src_r, src_nxt;
  logic [4:0]             remain_r, remain_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;

  logic [LENGTH_BITS-1:0] cnt_inc;
  logic                   limit_hit;
  logic                   limit_after;
  logic [15:0]            flags_sh;
  logic [15:0]            cur_flags;
  logic                   is_flag_byte;
  logic                   done;
  logic                   restart;
  logic                   fire;

  // Saturating output count and the limit checks before and after one byte.
  assign cnt_inc     = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
  assign limit_hit   = cfg.stop && (CFG_W'(cnt_r) >= cfg.length);
  assign limit_after = cfg.stop && (CFG_W'(cnt_inc) >= cfg.length);

  // Flag bits as seen at the start of a token.
  assign flags_sh     = {1'b0, flags_r[15:1]};
  assign is_flag_byte = (phase_r != PH_FIRST) && !flags_sh[8];
  assign cur_flags    = (phase_r == PH_FIRST) ? flags_r : flags_sh;

  assign in_ready    = (state_r == S_IDLE);
  assign win_rd_addr = src_r;
  assign win_wr_data = emit.data;
  assign fire        = emit.valid && emit_ready;

  // Next-state logic.
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    flags_nxt  = flags_r;
    offlo_nxt  = offlo_r;
    lit_nxt    = lit_r;
    last_nxt   = last_r;
    src_nxt    = src_r;
    remain_nxt = remain_r;
    cnt_nxt    = cnt_r;
    done       = 1'b0;
    restart    = 1'b0;
    emit       = '0;
    win_ctl    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          if (phase_r == PH_SECOND) begin
            // Second match byte: start the copy.
            src_nxt    = AW'({in_byte[7:4], offlo_r});
            remain_nxt = {1'b0, in_byte[3:0]} + MIN_MATCH;
            phase_nxt  = PH_START;
            state_nxt  = S_RD;
          end else if (is_flag_byte) begin
            flags_nxt = {8'hFF, in_byte};
            phase_nxt = PH_FIRST;
            restart   = in_last;
          end else begin
            flags_nxt = cur_flags;
            if (cur_flags[0]) begin
              lit_nxt   = in_byte;
              phase_nxt = PH_START;
              state_nxt = S_LIT;
            end else begin
              offlo_nxt = in_byte;
              phase_nxt = PH_SECOND;
              restart   = in_last;
            end
          end
        end
      end
      S_LIT: begin
        if (limit_hit) begin
          done = 1'b1;
        end else begin
          emit.valid = 1'b1;
          emit.data  = lit_r;
          emit.last  = 1'b1;
          done       = emit_ready;
        end
      end
      S_RD: begin
        // Once the limit is reached the rest of the match is dropped.
        if (limit_hit) begin
          done = 1'b1;
        end else begin
          win_ctl.rd_en = 1'b1;
          state_nxt     = S_WR;
        end
      end
      S_WR: begin
        emit.valid = 1'b1;
        emit.data  = win_rd_data;
        emit.last  = (remain_r == 5'd1) || limit_after;
        if (emit_ready) begin
          src_nxt    = src_r + 1'b1;
          remain_nxt = remain_r - 5'd1;
          if (emit.last) begin
            done = 1'b1;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Every emitted byte is counted and written into the window.
    win_ctl.wr_en = fire;
    if (fire) begin
      cnt_nxt = cnt_inc;
    end

    if (done) begin
      state_nxt = S_IDLE;
      restart   = last_r;
    end

    // The final input byte of a stream returns the decoder to its start.
    if (restart) begin
      phase_nxt = PH_START;
      flags_nxt = '0;
      offlo_nxt = '0;
      cnt_nxt   = '0;
    end
    win_ctl.restart = restart;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_START;
      flags_r <= '0;
      offlo_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      offlo_r <= offlo_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Token payload registers.
  always_ff @(posedge clk) begin
    lit_r    <= lit_nxt;
    last_r   <= last_nxt;
    src_r    <= src_nxt;
    remain_r <= remain_nxt;
  end

endmodule

@@ rtl/lzss_window_decoder.sv @@
// ----------------------------------------------------------------------------
// LZSS window decoder
// Decodes an LZSS stream with a 4096-byte history window and 12-bit offsets,
// one compressed byte per request, producing up to 18 bytes per request.
//
//   channel  direction  signals
//   in_      input      in_valid, in_ready, in_byte, in_last_in_byte
//   out_     output     out_valid, out_ready, out_byte, out_last_of_run
//   cfg_     input      cfg_we, cfg_index, cfg_data
//
// A flag byte or first match byte is taken in the idle state; a literal is
// emitted from its own state. A match copies each byte by a window read,
// then an emit and write-back; no new byte is taken until a literal or match
// is done. Reset is synchronous; no clearing pass is needed because a fill
// count marks unwritten window entries as zero. An output register
// decouples the sides; a stalled output holds the copy loop in its emit step.
// ----------------------------------------------------------------------------
module lzss_window_decoder
  import lzsswd_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last_in_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_run,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(WINDOW_SIZE);

  cfg_t          cfg_r;
  emit_t         emit;
  logic          emit_ready;
  win_ctl_t      win_ctl;
  logic [AW-1:0] win_rd_addr;
  logic [7:0]    win_wr_data;
  logic [7:0]    win_rd_data;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STOP:   cfg_r.stop   <= cfg_data[0];
        REG_LENGTH: cfg_r.length <= cfg_data;
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  lzsswd_ctrl #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last_in_byte),
    .cfg         (cfg_r),
    .emit        (emit),
    .emit_ready  (emit_ready),
    .win_ctl     (win_ctl),
    .win_rd_addr (win_rd_addr),
    .win_wr_data (win_wr_data),
    .win_rd_data (win_rd_data)
  );

  lzsswd_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .rd_addr (win_rd_addr),
    .wr_data (win_wr_data),
    .rd_data (win_rd_data)
  );

  // Output register: takes a new byte when empty or being drained.
  assign emit_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid && emit_ready) begin
      out_byte_r <= emit.data;
      out_last_r <= emit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

@@ tb/lzss_window_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// LZSS window decoder testbench
// Feeds compressed byte streams through the decoder and checks every decoded
// byte against a bit-accurate predictor kept in a scoreboard. The run covers
// hand-built token sequences (overlapping copies, window wrap, streams cut
// mid-token) and then random well-formed streams mixed with noise, in
// free-running mode and in limit mode with several output lengths. Both
// handshakes idle at random, except in random streams sent in steady mode.
// ----------------------------------------------------------------------------
module lzss_window_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lzsswd_pkg::*;

  // Cycles without any request moving before the run is declared hung.
  localparam int IDLE_LIMIT   = 2000;
  // Cycles allowed for the longest silent match to finish before a register
  // write or the end of the run.
  localparam int DRAIN_CYCLES = 48;
  // Mismatch lines printed before reporting goes quiet.
  localparam int PRINT_CAP    = 40;

  // One decoded byte as seen on the result channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  // One compressed byte queued for the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } comp_byte_t;

  // Scoreboard: predicts decoded bytes for each accepted request and checks
  // the result channel against them in order.
  class lzss_scoreboard;
    logic [7:0]  hist [WINDOW_SIZE_DEF];
    logic [11:0] wr_pos;
    logic [15:0] flag_reg;
    logic [1:0]  phase;
    logic [7:0]  offset_lo;
    logic [31:0] emitted;
    logic        stop_mode;
    logic [31:0] length_limit;
    dec_byte_t   expected_q[$];
    int          mismatches;
    int          bytes_in;
    int          bytes_out;

    function new();
      restart();
      stop_mode    = 1'b0;
      length_limit = '0;
      mismatches   = 0;
      bytes_in     = 0;
      bytes_out    = 0;
    endfunction

    // Decoder state after reset or after the final byte of a stream.
    function void restart();
      foreach (hist[i]) hist[i] = 8'h00;
      wr_pos    = WPOS_START;
      flag_reg  = '0;
      phase     = PH_START;
      offset_lo = '0;
      emitted   = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_STOP:   stop_mode = data[0];
        REG_LENGTH: length_limit = data;
        default: ;
      endcase
    endfunction

    // Emit one decoded byte unless the length limit drops it.
    function void put_byte(logic [7:0] b);
      if (stop_mode && emitted >= length_limit) return;
      if (emitted != '1) emitted++;
      hist[wr_pos] = b;
      wr_pos++;
      expected_q.push_back('{data: b, last: 1'b0});
    endfunction

    // Advance the predictor by one accepted compressed byte.
    function void note_request(logic [7:0] b, logic last_in);
      int          queued_at_start;
      logic        flag_byte;
      logic [11:0] src;
      logic [4:0]  run_len;
      queued_at_start = expected_q.size();
      flag_byte       = 1'b0;
      bytes_in++;
      // Phase code three behaves like the start of a token.
      if (phase != PH_FIRST && phase != PH_SECOND) begin
        flag_reg = flag_reg >> 1;
        if (!flag_reg[8]) begin
          flag_reg  = {8'hFF, b};
          flag_byte = 1'b1;
        end
        phase = PH_FIRST;
      end
      if (!flag_byte) begin
        if (phase == PH_FIRST) begin
          if (flag_reg[0]) begin
            put_byte(b);
            phase = PH_START;
          end else begin
            offset_lo = b;
            phase     = PH_SECOND;
          end
        end else begin
          // Copy byte by byte so an overlapping source sees fresh writes.
          src     = {b[7:4], offset_lo};
          run_len = {1'b0, b[3:0]} + MIN_MATCH;
          for (int i = 0; i < run_len; i++) begin
            put_byte(hist[src]);
            src++;
          end
          phase = PH_START;
        end
      end
      if (expected_q.size() > queued_at_start)
        expected_q[expected_q.size() - 1].last = 1'b1;
      if (last_in) restart();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Compare one accepted result with the oldest prediction.
    task check_result(logic [7:0] b, logic last_out);
      dec_byte_t want;
      bytes_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("byte %02h (last %0b) with nothing predicted", b, last_out));
        return;
      end
      want = expected_q.pop_front();
      if (b !== want.data)
        report($sformatf("out_byte %02h, predicted %02h", b, want.data));
      if (last_out !== want.last)
        report($sformatf("out_last_of_run %0b, predicted %0b on byte %02h",
                         last_out, want.last, want.data));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_byte;
  logic                 in_last_in_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_byte;
  logic                 out_last_of_run;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lzss_scoreboard sb = new();
  comp_byte_t     stream_q[$];
  // When set, neither side idles.
  bit             steady = 1'b0;

  lzss_window_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last_in_byte (in_last_in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: stall a random number of cycles before each byte.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_byte, out_last_of_run);
  end

  // Hang detection: give up after a long stretch with no request moving.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Timeout: %0d cycles with no request moving", IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one compressed byte after a random gap and wait for acceptance.
  task automatic send_req(input logic [7:0] b, input logic last_in);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_last_in_byte <= last_in;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(b, last_in);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_req(stream_q[i].data, stream_q[i].last);
  endtask

  // Hold the input until every predicted byte has come out and the decoder
  // has had time to finish a match whose bytes are all dropped.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_byte(logic [7:0] b, logic last_in);
    stream_q.push_back('{data: b, last: last_in});
  endfunction

  // Match token: offsets mostly land in the region a fresh stream has just
  // written, around the start position and across the wrap.
  function automatic void add_match();
    logic [11:0] off;
    logic [3:0]  len_code;
    if ($urandom_range(0, 3) == 0) off = 12'($urandom);
    else off = WPOS_START + 12'($urandom_range(0, 400));
    len_code = 4'($urandom);
    add_byte(off[7:0], 1'b0);
    add_byte({off[11:8], len_code}, 1'b0);
  endfunction

  // Flag byte followed by the eight tokens it announces.
  function automatic void add_group();
    logic [7:0] flag;
    flag = 8'($urandom);
    add_byte(flag, 1'b0);
    for (int k = 0; k < 8; k++) begin
      if (flag[k]) add_byte(8'($urandom), 1'b0);
      else add_match();
    end
  endfunction

  // Random traffic: mostly complete streams, some cut short or left open,
  // and some noise with stray end marks.
  task automatic run_random(input int quota);
    int sent;
    int pick;
    int cut;
    sent = 0;
    while (sent < quota) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 9);
      stream_q.delete();
      if (pick < 9) begin
        repeat ($urandom_range(1, 2)) add_group();
        if (pick == 7) begin
          cut = $urandom_range(1, 3);
          repeat (cut) void'(stream_q.pop_back());
        end
        if (pick != 8) stream_q[stream_q.size() - 1].last = 1'b1;
      end else begin
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
      sent += stream_q.size();
      send_stream();
    end
    steady = 1'b0;
  endtask

  // Hand-built streams: overlapping copy, copy across the window wrap,
  // longest and shortest matches, literal extremes, and the end mark on a
  // flag byte, on a literal and in the middle of a match.
  task automatic run_directed();
    stream_q.delete();
    add_byte(8'h05, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hEE, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'hA5, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hF3, 1'b0);
    add_byte(8'hF2, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h0F, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h5A, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h55, 1'b1);
    send_stream();
  endtask

  // Main sequence.
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_byte         = 8'h00;
    in_last_in_byte = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_STOP;
    cfg_data        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Free-running decode.
    write_reg(REG_STOP, '0);
    write_reg(REG_LENGTH, '0);
    run_directed();
    settle();
    run_random(70);
    settle();

    // Limit mode with a zero length: every byte is dropped.
    write_reg(REG_STOP, CFG_W'(1));
    write_reg(REG_LENGTH, '0);
    run_random(12);
    settle();

    // Limit mode with a short length that cuts streams mid-match.
    write_reg(REG_LENGTH, CFG_W'($urandom_range(1, 40)));
    run_random(55);
    settle();

    // Limit mode with the largest length.
    write_reg(REG_LENGTH, '1);
    run_random(28);
    settle();

    // Back to free-running with an arbitrary stored length.
    write_reg(REG_STOP, '0);
    write_reg(REG_LENGTH, CFG_W'($urandom));
    run_random(30);
    settle();

    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d predicted bytes never came out", sb.expected_q.size()));
    $display("Decoded %0d compressed bytes into %0d output bytes, free-running and limited,",
             sb.bytes_in, sb.bytes_out);
    $display("with random stalls on both sides; %0d mismatches.", sb.mismatches);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
rtl/lzsswd_pkg.sv
rtl/lzsswd_window.sv
rtl/lzsswd_ctrl.sv
rtl/lzss_window_decoder.sv
tb/lzss_window_decoder_tb.sv
